FILE: design/mkeval_pkg.sv
// Shared types and constants for the Matern kernel evaluation unit.
// Used by the front, queue, back and top-level modules; no dependencies.
package mkeval_pkg;

	// Distance width carried to the back end: r < 64.0 in Q16.16
	localparam int unsigned R_W       = 22;
	localparam int unsigned EXP_TERMS = 20;
	// Whole units of r that can still give a nonzero result
	localparam int unsigned POW_STEPS = 63;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [63:0] ONE60     = 64'd1 << 60;
	localparam logic [31:0] FAR_LIMIT = 32'd64 << 16;
	// 2^64 / 3 rounded up, exact for dividends below 2^62
	localparam logic [63:0] RECIP3    = 64'h5555555555555556;

	// exp(-1) in Q0.60 as the truncated series produces it: every term is
	// floor(2^60 / i!), so the sum is known at elaboration
	localparam logic [63:0] E_NEG_ONE =
		ONE60 - ONE60 / 64'd1 + ONE60 / 64'd2 - ONE60 / 64'd6
		+ ONE60 / 64'd24 - ONE60 / 64'd120 + ONE60 / 64'd720
		- ONE60 / 64'd5040 + ONE60 / 64'd40320 - ONE60 / 64'd362880
		+ ONE60 / 64'd3628800 - ONE60 / 64'd39916800 + ONE60 / 64'd479001600
		- ONE60 / 64'd6227020800 + ONE60 / 64'd87178291200
		- ONE60 / 64'd1307674368000 + ONE60 / 64'd20922789888000
		- ONE60 / 64'd355687428096000 + ONE60 / 64'd6402373705728000
		- ONE60 / 64'd121645100408832000 + ONE60 / 64'd2432902008176640000;

	// Configuration register indexes
	localparam int unsigned REG_DIM_COUNT = 0;
	localparam int unsigned REG_MODE      = 1;
	localparam int unsigned REG_AMPLITUDE = 2;
	localparam int unsigned REG_NUGGET    = 3;
	localparam int unsigned REG_SCALE0    = 4;

	// Smoothness modes (any other code means nu = 5/2)
	localparam logic [1:0] MODE_NU_HALF  = 2'd0;
	localparam logic [1:0] MODE_NU_3HALF = 2'd1;

	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_ZERO,
		KIND_FAR
	} kind_t;

	// Classified distance handed from front to back
	typedef struct packed {
		kind_t          kind;
		logic           sat;
		logic [R_W-1:0] r;
	} item_t;

endpackage

FILE: design/mkeval_mul.sv
// Two-stage 64x64 multiplier built from four 32x32 partial products.
// Gives bits [SH+63:SH] of the product and carries a side payload along.
module mkeval_mul #(
	parameter int unsigned SH     = 60,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [63:0]       p,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s1;
	logic              v_s2;
	logic [63:0]       pp_s1 [4];
	logic [SIDE_W-1:0] side_s1;
	logic [SIDE_W-1:0] side_s2;
	logic [63:0]       p_s2;
	logic [191:0]      full;

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// partial products, then the sum and the window
	assign full = 192'(pp_s1[0]) + (192'(pp_s1[1]) << 32) + (192'(pp_s1[2]) << 32)
		+ (192'(pp_s1[3]) << 64);

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= 64'(a[31:0]) * 64'(b[31:0]);
			pp_s1[1] <= 64'(a[31:0]) * 64'(b[63:32]);
			pp_s1[2] <= 64'(a[63:32]) * 64'(b[31:0]);
			pp_s1[3] <= 64'(a[63:32]) * 64'(b[63:32]);
			side_s1  <= side_in;
			p_s2     <= full[SH +: 64];
			side_s2  <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign p         = p_s2;
	assign side_out  = side_s2;

endmodule

FILE: design/mkeval_front.sv
// Front end: scaled differences, sum of squares, pipelined bit-by-bit square root
// and classification of the distance. Depends on mkeval_pkg.
module mkeval_front #(
	parameter int unsigned MAX_DIMS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [64*MAX_DIMS-1:0]     in_data,
	input  logic [2:0]                 dim_count,
	input  logic [MAX_DIMS-1:0][31:0]  scale,
	output logic                       out_valid,
	input  logic                       out_ready,
	output mkeval_pkg::item_t          out_item
);
	import mkeval_pkg::*;

	localparam int unsigned SUM_W  = 65 + $clog2(MAX_DIMS);
	localparam int unsigned ROOT_W = 32;

	logic en;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [32:0]       mag_s1  [MAX_DIMS];
	logic [63:0]       prod_s2 [MAX_DIMS];
	logic [31:0]       dx_s3   [MAX_DIMS];
	logic              sat_s3;
	logic [63:0]       sq_s4   [MAX_DIMS];
	logic              sat_s4;
	logic [63:0]       sum_s5;
	logic              sat_s5;

	logic [ROOT_W-1:0] sqv_q;
	logic [63:0]       rem_q   [ROOT_W];
	logic [31:0]       root_q  [ROOT_W];
	logic              sqsat_q [ROOT_W];

	logic [32:0]       mag_c   [MAX_DIMS];
	logic [31:0]       dx_c    [MAX_DIMS];
	logic              sat_c;
	logic [SUM_W-1:0]  total_c;
	logic [63:0]       src_rem  [ROOT_W];
	logic [31:0]       src_root [ROOT_W];
	logic              src_sat  [ROOT_W];
	logic [63:0]       nrem     [ROOT_W];
	logic [31:0]       nroot    [ROOT_W];
	logic [31:0]       root_fin;

	// whole front advances unless its result is held back by the queue
	assign en       = !sqv_q[ROOT_W-1] || out_ready;
	assign in_ready = en;

	// per-lane magnitude of the difference, unused lanes forced to zero
	always_comb begin
		logic [32:0] diff;
		for (int d = 0; d < MAX_DIMS; d++) begin
			diff = {in_data[32*d+31], in_data[32*d +: 32]}
				- {in_data[32*(MAX_DIMS+d)+31], in_data[32*(MAX_DIMS+d) +: 32]};
			mag_c[d] = diff[32] ? 33'(-diff) : diff;
			if ({29'd0, dim_count} <= 32'(d)) begin
				mag_c[d] = '0;
			end
		end
	end

	// rounding and clipping of the scaled differences
	always_comb begin
		logic [64:0] rnd;
		sat_c = 1'b0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			rnd = {1'b0, prod_s2[d]} + (65'd1 << 23);
			if (|rnd[64:56]) begin
				dx_c[d] = '1;
				sat_c   = 1'b1;
			end else begin
				dx_c[d] = rnd[55:24];
			end
		end
	end

	// sum of squares across lanes
	always_comb begin
		total_c = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			total_c = total_c + SUM_W'(sq_s4[d]);
		end
	end

	// one root bit per stage, most significant first
	always_comb begin
		logic [65:0] trial;
		src_rem[0]  = sum_s5;
		src_root[0] = '0;
		src_sat[0]  = sat_s5;
		for (int t = 1; t < ROOT_W; t++) begin
			src_rem[t]  = rem_q[t-1];
			src_root[t] = root_q[t-1];
			src_sat[t]  = sqsat_q[t-1];
		end
		for (int t = 0; t < ROOT_W; t++) begin
			trial = ({34'd0, src_root[t]} << (ROOT_W - t))
				+ (66'd1 << (2 * (ROOT_W - 1 - t)));
			if ({2'b00, src_rem[t]} >= trial) begin
				nrem[t]  = 64'({2'b00, src_rem[t]} - trial);
				nroot[t] = src_root[t] | (32'd1 << (ROOT_W - 1 - t));
			end else begin
				nrem[t]  = src_rem[t];
				nroot[t] = src_root[t];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			sqv_q <= '0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			sqv_q <= {sqv_q[ROOT_W-2:0], v_s5};
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				mag_s1[d]  <= mag_c[d];
				prod_s2[d] <= 64'(mag_s1[d]) * 64'(scale[d]);
				dx_s3[d]   <= dx_c[d];
				sq_s4[d]   <= 64'(dx_s3[d]) * 64'(dx_s3[d]);
			end
			sat_s3 <= sat_c;
			sat_s4 <= sat_s3;
			sum_s5 <= (|total_c[SUM_W-1:64]) ? '1 : total_c[63:0];
			sat_s5 <= sat_s4 || (|total_c[SUM_W-1:64]);
			for (int t = 0; t < ROOT_W; t++) begin
				rem_q[t]   <= nrem[t];
				root_q[t]  <= nroot[t];
				sqsat_q[t] <= src_sat[t];
			end
		end
	end

	// classify the distance
	assign root_fin  = root_q[ROOT_W-1];
	assign out_valid = sqv_q[ROOT_W-1];

	always_comb begin
		out_item.sat = sqsat_q[ROOT_W-1];
		out_item.r   = root_fin[R_W-1:0];
		priority if (root_fin == '0) begin
			out_item.kind = KIND_ZERO;
		end else if (root_fin >= FAR_LIMIT) begin
			out_item.kind = KIND_FAR;
		end else begin
			out_item.kind = KIND_NORMAL;
		end
	end

endmodule

FILE: design/mkeval_fifo.sv
// Short queue of classified distances between front and back.
// Depends on mkeval_pkg for the item type and depth.
module mkeval_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  mkeval_pkg::item_t push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output mkeval_pkg::item_t pop_item
);
	import mkeval_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: design/mkeval_back.sv
// Back end: exp(-frac(r)) by truncated series, whole-unit powers of exp(-1),
// polynomial factor and final rounding. Depends on mkeval_pkg, mkeval_mul.
module mkeval_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mkeval_pkg::item_t in_item,
	input  logic [1:0]        mode,
	input  logic [31:0]       amplitude,
	input  logic [31:0]       nugget,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       covariance,
	output logic              saturated
);
	import mkeval_pkg::*;

	typedef struct packed {
		item_t       it;
		logic [63:0] sum;
		logic [63:0] x;
	} exp_side_t;

	typedef struct packed {
		item_t       it;
		logic [63:0] e;
	} pow_side_t;

	typedef struct packed {
		item_t       it;
		logic [63:0] ae;
		logic [63:0] aer;
	} fin_side_t;

	localparam int unsigned EXP_SW = $bits(exp_side_t);
	localparam int unsigned POW_SW = $bits(pow_side_t);
	localparam int unsigned FIN_SW = $bits(fin_side_t);

	logic        en;
	logic        out_valid_q;
	logic [31:0] cov_q;
	logic        sat_q;
	logic [63:0] nug_prod_q;

	wire              ea_v    [EXP_TERMS];
	wire [63:0]       ea_p    [EXP_TERMS];
	wire exp_side_t   ea_side [EXP_TERMS];
	wire              eb_v    [EXP_TERMS];
	wire [63:0]       eb_p    [EXP_TERMS];
	wire exp_side_t   eb_side [EXP_TERMS];
	wire [63:0]       esum    [EXP_TERMS];

	wire              pw_v    [POW_STEPS];
	wire [63:0]       pw_p    [POW_STEPS];
	wire pow_side_t   pw_side [POW_STEPS];
	wire [63:0]       pw_e    [POW_STEPS];

	wire              f1_v, f2_v, f3_v, f4_v;
	wire [63:0]       f1_p, f2_p, f3_p, f4_p;
	wire pow_side_t   f1_side;
	wire fin_side_t   f2_side, f3_side, f4_side;

	// the whole back end moves together, held only by the output register
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// series terms: term = floor(term * x) / i, sum alternates in sign
	for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
		localparam int unsigned DIV = i + 1;
		localparam int unsigned LG  = $clog2(DIV);
		localparam int unsigned DSH = 61 + LG;
		localparam logic [191:0] RECIP_W =
			((192'd1 << DSH) + 192'(DIV) - 192'd1) / 192'(DIV);

		logic        v_in;
		logic [63:0] term_in;
		logic [63:0] sum_in;
		logic [63:0] x_in;
		item_t       it_in;
		exp_side_t   side_a;

		if (i == 0) begin : g_head
			assign v_in    = in_valid;
			assign term_in = ONE60;
			assign sum_in  = ONE60;
			assign x_in    = {4'd0, in_item.r[15:0], 44'd0};
			assign it_in   = in_item;
		end else begin : g_tail
			assign v_in    = eb_v[i-1];
			assign term_in = eb_p[i-1];
			assign sum_in  = esum[i-1];
			assign x_in    = eb_side[i-1].x;
			assign it_in   = eb_side[i-1].it;
		end

		assign side_a = '{it: it_in, sum: sum_in, x: x_in};

		mkeval_mul #(.SH(60), .SIDE_W(EXP_SW)) u_mul_x (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v_in), .a(term_in), .b(x_in), .side_in(side_a),
			.out_valid(ea_v[i]), .p(ea_p[i]), .side_out(ea_side[i])
		);

		// exact division by the term index through its reciprocal
		mkeval_mul #(.SH(DSH), .SIDE_W(EXP_SW)) u_mul_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(ea_v[i]), .a(ea_p[i]), .b(RECIP_W[63:0]), .side_in(ea_side[i]),
			.out_valid(eb_v[i]), .p(eb_p[i]), .side_out(eb_side[i])
		);

		if ((DIV % 2) == 1) begin : g_odd
			assign esum[i] = eb_side[i].sum - eb_p[i];
		end else begin : g_even
			assign esum[i] = eb_side[i].sum + eb_p[i];
		end
	end

	// one multiply by exp(-1) per whole unit of r; steps past the whole part of r pass e through
	for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow
		logic        v_in;
		logic [63:0] e_in;
		item_t       it_in;
		pow_side_t   side_a;

		if (j == 0) begin : g_head
			assign v_in  = eb_v[EXP_TERMS-1];
			assign e_in  = esum[EXP_TERMS-1];
			assign it_in = eb_side[EXP_TERMS-1].it;
		end else begin : g_tail
			assign v_in  = pw_v[j-1];
			assign e_in  = pw_e[j-1];
			assign it_in = pw_side[j-1].it;
		end

		assign side_a = '{it: it_in, e: e_in};

		mkeval_mul #(.SH(60), .SIDE_W(POW_SW)) u_mul_e1 (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v_in), .a(e_in), .b(E_NEG_ONE), .side_in(side_a),
			.out_valid(pw_v[j]), .p(pw_p[j]), .side_out(pw_side[j])
		);

		assign pw_e[j] = (pw_side[j].it.r[R_W-1:16] > 6'(j)) ? pw_p[j] : pw_side[j].e;
	end

	// amplitude times exp(-r), Q.44
	mkeval_mul #(.SH(32), .SIDE_W(POW_SW)) u_mul_amp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(pw_v[POW_STEPS-1]), .a({32'd0, amplitude}), .b(pw_e[POW_STEPS-1]),
		.side_in(pow_side_t'{it: pw_side[POW_STEPS-1].it, e: pw_e[POW_STEPS-1]}),
		.out_valid(f1_v), .p(f1_p), .side_out(f1_side)
	);

	// times r
	mkeval_mul #(.SH(16), .SIDE_W(FIN_SW)) u_mul_r1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f1_v), .a(f1_p), .b({42'd0, f1_side.it.r}),
		.side_in(fin_side_t'{it: f1_side.it, ae: f1_p, aer: 64'd0}),
		.out_valid(f2_v), .p(f2_p), .side_out(f2_side)
	);

	// times r again
	mkeval_mul #(.SH(16), .SIDE_W(FIN_SW)) u_mul_r2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f2_v), .a(f2_p), .b({42'd0, f2_side.it.r}),
		.side_in(fin_side_t'{it: f2_side.it, ae: f2_side.ae, aer: f2_p}),
		.out_valid(f3_v), .p(f3_p), .side_out(f3_side)
	);

	// r^2 term over three
	mkeval_mul #(.SH(64), .SIDE_W(FIN_SW)) u_mul_third (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f3_v), .a(f3_p), .b(RECIP3), .side_in(f3_side),
		.out_valid(f4_v), .p(f4_p), .side_out(f4_side)
	);

	// amplitude * nugget, settled long before any item needs it
	always_ff @(posedge clk) begin
		nug_prod_q <= 64'(amplitude) * 64'(nugget);
	end

	// combine, round and clip
	logic [63:0] tot_c;
	logic [64:0] rnd_c;
	logic [49:0] zero_c;
	logic [49:0] res_c;
	logic        clip_c;

	always_comb begin
		logic [64:0] nug_rnd;
		tot_c = f4_side.ae;
		if (mode != MODE_NU_HALF) begin
			tot_c = tot_c + f4_side.aer;
			if (mode != MODE_NU_3HALF) begin
				tot_c = tot_c + f4_p;
			end
		end
		rnd_c   = {1'b0, tot_c} + (65'd1 << 27);
		nug_rnd = {1'b0, nug_prod_q} + (65'd1 << 15);
		zero_c  = {18'd0, amplitude} + 50'(nug_rnd[64:16]);
		unique case (f4_side.it.kind)
			KIND_ZERO:   res_c = zero_c;
			KIND_FAR:    res_c = '0;
			KIND_NORMAL: res_c = {13'd0, rnd_c[64:28]};
			default:     res_c = '0;
		endcase
		clip_c = |res_c[49:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= f4_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cov_q <= clip_c ? '1 : res_c[31:0];
			sat_q <= f4_side.it.sat || clip_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign covariance = cov_q;
	assign saturated  = sat_q;

endmodule

FILE: design/matern_kernel_eval_unit.sv
// Matern covariance evaluation, one point pair per cycle when the result stream
// does not stall. An input pair loads into the first front stage on the transfer
// edge, then passes through 36 further front stages, the queue, 214 multiplier
// stages in the back and the output register. Throughput: one pair per clock when
// the result stream does not stall, set by the fully pipelined square root and the
// chain of two-stage 64-bit multipliers. Reset clears all valid state and loads the
// configuration registers with their defaults; no clearing pass.
module matern_kernel_eval_unit #(
	parameter int unsigned MAX_DIMS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [$clog2(4 + MAX_DIMS)-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data,
	// point pair stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// row_coord_0..row_coord_(MAX_DIMS-1), col_coord_0..col_coord_(MAX_DIMS-1)
	input  logic [64*MAX_DIMS-1:0]              s_axis_tdata,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// covariance
	output logic [31:0]                         m_axis_tdata,
	// saturated
	output logic                                m_axis_tuser
);
	import mkeval_pkg::*;

	localparam int unsigned IDX_W = $clog2(4 + MAX_DIMS);

	logic [2:0]                dim_count_q;
	logic [1:0]                mode_q;
	logic [31:0]               amplitude_q;
	logic [31:0]               nugget_q;
	logic [MAX_DIMS-1:0][31:0] scale_q;

	logic  front_valid;
	logic  front_ready;
	item_t front_item;
	logic  queue_valid;
	logic  queue_ready;
	item_t queue_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 3'd1;
			mode_q      <= MODE_NU_HALF;
			amplitude_q <= 32'd65536;
			nugget_q    <= '0;
			for (int d = 0; d < MAX_DIMS; d++) begin
				scale_q[d] <= 32'd16777216;
			end
		end else if (cfg_we) begin
			if (cfg_index == IDX_W'(REG_DIM_COUNT)) begin
				dim_count_q <= cfg_data[2:0];
			end
			if (cfg_index == IDX_W'(REG_MODE)) begin
				mode_q <= cfg_data[1:0];
			end
			if (cfg_index == IDX_W'(REG_AMPLITUDE)) begin
				amplitude_q <= cfg_data;
			end
			if (cfg_index == IDX_W'(REG_NUGGET)) begin
				nugget_q <= cfg_data;
			end
			for (int d = 0; d < MAX_DIMS; d++) begin
				if (cfg_index == IDX_W'(REG_SCALE0 + d)) begin
					scale_q[d] <= cfg_data;
				end
			end
		end
	end

	mkeval_front #(.MAX_DIMS(MAX_DIMS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.dim_count (dim_count_q),
		.scale     (scale_q),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	mkeval_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	mkeval_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (queue_valid),
		.in_ready   (queue_ready),
		.in_item    (queue_item),
		.mode       (mode_q),
		.amplitude  (amplitude_q),
		.nugget     (nugget_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.covariance (m_axis_tdata),
		.saturated  (m_axis_tuser)
	);

endmodule

FILE: verif/matern_kernel_eval_unit_tb.sv
// Self-checking testbench for matern_kernel_eval_unit: point pairs stream in,
// a bit-exact Matern covariance predictor checks each result in order.
// Depends on design/mkeval_pkg.sv and design/matern_kernel_eval_unit.sv.
`timescale 1ns / 1ps

module matern_kernel_eval_unit_tb;
	import mkeval_pkg::*;

	localparam int unsigned NDIM   = 4;
	localparam int unsigned N_REGS = 4 + NDIM;
	localparam logic [63:0] FRAC_ONE = 64'd1 << 60;

	// Matern covariance predictor plus the queue of results still owed
	class kernel_scoreboard;
		bit [2:0]  dim_count;
		bit [1:0]  mode;
		bit [31:0] amp;
		bit [31:0] nugget;
		bit [31:0] scale[NDIM];
		bit [63:0] exp_neg_one;
		bit [32:0] owed[$];
		int        errors;

		function new();
			dim_count = 1;
			mode      = 0;
			amp       = 32'd65536;
			nugget    = 0;
			foreach (scale[d]) scale[d] = 32'd1 << 24;
			errors    = 0;
			exp_neg_one = exp_neg(FRAC_ONE);
		endfunction

		function void set_reg(int idx, bit [31:0] v);
			if (idx == REG_DIM_COUNT) dim_count = v[2:0];
			else if (idx == REG_MODE) mode = v[1:0];
			else if (idx == REG_AMPLITUDE) amp = v;
			else if (idx == REG_NUGGET) nugget = v;
			else if (idx < N_REGS) scale[idx - REG_SCALE0] = v;
		endfunction

		// floor(a*b / 2^s), low 64 bits kept
		function bit [63:0] mul_shr(bit [63:0] a, bit [63:0] b, int s);
			bit [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return 64'(p >> s);
		endfunction

		// truncated Taylor series of exp(-x), x in Q0.60
		function bit [63:0] exp_neg(bit [63:0] x);
			bit [63:0] acc, term;
			acc  = FRAC_ONE;
			term = FRAC_ONE;
			for (int i = 1; i <= 20; i++) begin
				term = mul_shr(term, x, 60) / 64'(i);
				if (i % 2) acc = acc - term;
				else acc = acc + term;
			end
			return acc;
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] v);
			bit [63:0] root, b;
			root = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= root + b) begin
					v = v - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		// returns {saturated, covariance}
		function bit [32:0] covariance_of(bit [64*NDIM-1:0] pair);
			bit        sat;
			int        n;
			bit [63:0] sum, a, b, diff, mag, sq, r, res, e, ae, tot, aer;
			bit [64:0] dx;
			sat = 0;
			sum = 0;
			n = (dim_count > NDIM) ? NDIM : dim_count;
			for (int d = 0; d < n; d++) begin
				a = {{32{pair[32*d+31]}}, pair[32*d +: 32]};
				b = {{32{pair[32*(NDIM+d)+31]}}, pair[32*(NDIM+d) +: 32]};
				diff = a - b;
				mag = diff[63] ? (64'd0 - diff) : diff;
				dx = ({1'b0, mag} * {33'd0, scale[d]} + (65'd1 << 23)) >> 24;
				if (dx > 65'hFFFF_FFFF) begin
					dx = 65'hFFFF_FFFF;
					sat = 1;
				end
				sq = dx[63:0] * dx[63:0];
				if (sum > ~sq) begin
					sum = '1;
					sat = 1;
				end else begin
					sum = sum + sq;
				end
			end
			r = int_sqrt(sum);
			if (r == 0) begin
				res = 64'(amp) + ((64'(amp) * 64'(nugget) + (64'd1 << 15)) >> 16);
			end else if (r >= 64'(FAR_LIMIT)) begin
				res = 0;
			end else begin
				e = exp_neg((r & 64'hFFFF) << 44);
				for (int i = 0; i < int'(r >> 16); i++) e = mul_shr(e, exp_neg_one, 60);
				ae = mul_shr(64'(amp), e, 32);
				tot = ae;
				if (mode != MODE_NU_HALF) begin
					aer = mul_shr(ae, r, 16);
					tot = tot + aer;
					if (mode != MODE_NU_3HALF) tot = tot + mul_shr(aer, r, 16) / 64'd3;
				end
				res = (tot + (64'd1 << 27)) >> 28;
			end
			if (res > 64'hFFFF_FFFF) begin
				res = 64'hFFFF_FFFF;
				sat = 1;
			end
			return {sat, res[31:0]};
		endfunction

		function void note_input(bit [64*NDIM-1:0] pair);
			owed.push_back(covariance_of(pair));
		endfunction

		function void check(bit [31:0] cov, bit sat);
			bit [32:0] want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result cov=%h sat=%b", $time, cov, sat);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (want[31:0] !== cov) begin
				$display("%0t: covariance expected %h actual %h", $time, want[31:0], cov);
				errors++;
			end
			if (want[32] !== sat) begin
				$display("%0t: saturated expected %b actual %b", $time, want[32], sat);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [2:0]           cfg_index;
	logic [31:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// row_coord_0..3, col_coord_0..3
	logic [64*NDIM-1:0]   s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// covariance
	logic [31:0]          m_axis_tdata;
	// saturated
	logic                 m_axis_tuser;

	kernel_scoreboard sb;
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	bit [31:0]   regs[N_REGS];

	matern_kernel_eval_unit #(.MAX_DIMS(NDIM)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// result transfer check
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_pair(input bit [64*NDIM-1:0] pair);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pair;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(pair);
	endtask

	// all registers written back to back; only called with the pipe empty
	task automatic load_regs();
		for (int i = 0; i < N_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= regs[i];
			sb.set_reg(i, regs[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// scale near 1.0 with a random exponent, sometimes an extreme
	function automatic bit [31:0] pick_scale();
		case ($urandom_range(9))
			0: return 0;
			1: return '1;
			2: return $urandom;
			default: return (32'd1 << 24) >> $urandom_range(6) | ($urandom & 32'hFFFF);
		endcase
	endfunction

	// mostly nearby points, so the distance lands inside the live range
	function automatic bit [64*NDIM-1:0] random_pair();
		bit [64*NDIM-1:0] p;
		bit [31:0]        delta;
		int unsigned      kind;
		kind = $urandom_range(99);
		for (int d = 0; d < NDIM; d++) begin
			p[32*d +: 32] = $urandom;
			delta = $urandom >> $urandom_range(31, 8);
			if (kind < 10) p[32*(NDIM+d) +: 32] = p[32*d +: 32];
			else if (kind < 25) p[32*(NDIM+d) +: 32] = $urandom;
			else p[32*(NDIM+d) +: 32] = p[32*d +: 32] + ($urandom_range(1) ? delta : -delta);
		end
		return p;
	endfunction

	// edge points: equal, extreme spread, one LSB, unit step, far apart
	function automatic bit [64*NDIM-1:0] edge_pair(int k);
		bit [64*NDIM-1:0] p;
		for (int d = 0; d < NDIM; d++) begin
			case (k)
				0: begin p[32*d +: 32] = 0; p[32*(NDIM+d) +: 32] = 0; end
				1: begin p[32*d +: 32] = 32'h7FFF_FFFF; p[32*(NDIM+d) +: 32] = 32'h8000_0000; end
				2: begin p[32*d +: 32] = 32'h8000_0000; p[32*(NDIM+d) +: 32] = 32'h7FFF_FFFF; end
				3: begin p[32*d +: 32] = 32'd1; p[32*(NDIM+d) +: 32] = 0; end
				4: begin p[32*d +: 32] = 32'h0001_0000; p[32*(NDIM+d) +: 32] = 0; end
				5: begin p[32*d +: 32] = 32'h0040_0000; p[32*(NDIM+d) +: 32] = 0; end
				6: begin p[32*d +: 32] = 32'h003F_FFFF; p[32*(NDIM+d) +: 32] = 0; end
				7: begin p[32*d +: 32] = '1; p[32*(NDIM+d) +: 32] = '1; end
				default: begin p[32*d +: 32] = 32'h0000_8000; p[32*(NDIM+d) +: 32] = 32'hFFFF_8000; end
			endcase
		end
		return p;
	endfunction

	initial begin
		sb = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults first, then a few corner settings
		for (int k = 0; k < 9; k++) send_pair(edge_pair(k));
		drain();
		for (int c = 0; c < 3; c++) begin
			regs[REG_DIM_COUNT] = (c == 0) ? 4 : (c == 1) ? 0 : 7;
			regs[REG_MODE]      = (c == 0) ? 3 : c;
			regs[REG_AMPLITUDE] = (c == 2) ? 0 : '1;
			regs[REG_NUGGET]    = (c == 0) ? '1 : 32'h0001_8000;
			for (int d = 0; d < NDIM; d++) regs[REG_SCALE0 + d] = (c == 0) ? '1 : 32'h0100_0000;
			load_regs();
			for (int k = 0; k < 5; k++) send_pair(edge_pair(k));
			drain();
		end

		// random phases, cycling through the idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 77; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 77; end
				default: begin src_idle_pct = 16; snk_stall_pct = 16; end
			endcase
			regs[REG_DIM_COUNT] = (ph == 0) ? 4 : $urandom_range(7);
			regs[REG_MODE]      = ph % 4;
			regs[REG_AMPLITUDE] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h40000);
			regs[REG_NUGGET]    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h20000);
			for (int d = 0; d < NDIM; d++) regs[REG_SCALE0 + d] = pick_scale();
			load_regs();
			for (int i = 0; i < 235; i++) send_pair(random_pair());
			drain();
		end

		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

FILE: filelist.f
design/mkeval_pkg.sv
design/mkeval_mul.sv
design/mkeval_front.sv
design/mkeval_fifo.sv
design/mkeval_back.sv
design/matern_kernel_eval_unit.sv
verif/matern_kernel_eval_unit_tb.sv
